// ===== rtl/core/wpfc_pkg.sv =====
// Package for the weighted pixel format converter.
// Holds format codes, register indexes, widths and the pipeline item types.
// Used by the interfaces, the cell modules and the top level.
`default_nettype none

package wpfc_pkg;

    // Widths of the payload and of the intermediate arithmetic.
    localparam int DATA_W     = 32;
    localparam int SUM_W      = DATA_W + 2;
    localparam int MEAN_BITS  = 35;
    localparam int MEAN_STEPS = 7;
    localparam int MEAN_CELLS = MEAN_BITS / MEAN_STEPS;
    localparam int DIV_CELLS  = DATA_W;
    localparam int LANES      = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FORMAT = 2'd1;

    // Pixel format codes. The last code is undefined and yields zeros.
    typedef enum logic [1:0] {
        FMT_GRAY     = 2'd0,
        FMT_PACKED   = 2'd1,
        FMT_SEPARATE = 2'd2,
        FMT_UNDEF    = 2'd3
    } t_fmt;

    // One input pixel as it travels down the pipeline.
    typedef struct packed {
        logic [DATA_W-1:0] rv;
        logic [DATA_W-1:0] gv;
        logic [DATA_W-1:0] bv;
        logic [DATA_W-1:0] rw;
        logic [DATA_W-1:0] gw;
        logic [DATA_W-1:0] bw;
        logic              last;
    } t_pix;

    // Division by three of the value sum and the weight sum, MSB first.
    typedef struct packed {
        logic [MEAN_BITS-1:0] dv;
        logic [MEAN_BITS-1:0] dw;
        logic [MEAN_BITS-1:0] qv;
        logic [MEAN_BITS-1:0] qw;
        logic [1:0]           remv;
        logic [1:0]           remw;
    } t_mean;

    typedef struct packed {
        t_pix  pix;
        t_mean m;
    } t_mst;

    // One channel of the restoring divider for v * m / w.
    typedef struct packed {
        logic [DATA_W-1:0] w;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] q;
        logic              sat;
        logic              zero;
    } t_lane;

    typedef struct packed {
        t_pix                   pix;
        logic [DATA_W-1:0]      mv;
        logic [DATA_W-1:0]      mw;
        t_lane [LANES-1:0]      lane;
    } t_dst;

endpackage

`default_nettype wire

// ===== rtl/core/wpfc_if.sv =====
// Handshake interfaces of the weighted pixel format converter.
// Pixel input, result output and configuration write channels.
// Depends on wpfc_pkg for widths.
`default_nettype none

interface wpfc_in_if;
    logic                       valid;
    logic                       ready;
    logic [wpfc_pkg::DATA_W-1:0] in_red_value;
    logic [wpfc_pkg::DATA_W-1:0] in_green_value;
    logic [wpfc_pkg::DATA_W-1:0] in_blue_value;
    logic [wpfc_pkg::DATA_W-1:0] in_red_weight;
    logic [wpfc_pkg::DATA_W-1:0] in_green_weight;
    logic [wpfc_pkg::DATA_W-1:0] in_blue_weight;
    logic                       in_last;

    modport source (output valid, in_red_value, in_green_value, in_blue_value,
                    in_red_weight, in_green_weight, in_blue_weight, in_last,
                    input ready);
    modport sink (input valid, in_red_value, in_green_value, in_blue_value,
                  in_red_weight, in_green_weight, in_blue_weight, in_last,
                  output ready);
endinterface

interface wpfc_out_if;
    logic                       valid;
    logic                       ready;
    logic [wpfc_pkg::DATA_W-1:0] out_red_value;
    logic [wpfc_pkg::DATA_W-1:0] out_green_value;
    logic [wpfc_pkg::DATA_W-1:0] out_blue_value;
    logic [wpfc_pkg::DATA_W-1:0] out_red_weight;
    logic [wpfc_pkg::DATA_W-1:0] out_green_weight;
    logic [wpfc_pkg::DATA_W-1:0] out_blue_weight;
    logic                       out_last;
    logic                       out_saturated;

    modport source (output valid, out_red_value, out_green_value, out_blue_value,
                    out_red_weight, out_green_weight, out_blue_weight, out_last,
                    out_saturated, input ready);
    modport sink (input valid, out_red_value, out_green_value, out_blue_value,
                  out_red_weight, out_green_weight, out_blue_weight, out_last,
                  out_saturated, output ready);
endinterface

interface wpfc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [wpfc_pkg::CFG_IDX_W-1:0]  index;
    logic [wpfc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wpfc_mean_cell.sv =====
// One cell of the divide-by-three chain for the value and weight sums.
// Retires MEAN_STEPS quotient bits per cycle while i_en is high; depends on wpfc_pkg.
`default_nettype none

module wpfc_mean_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wpfc_pkg::t_mst     i_data,
    output logic               o_valid,
    output wpfc_pkg::t_mst     o_data
);

    logic           r_valid;
    wpfc_pkg::t_mst r_data;
    wpfc_pkg::t_mst n_data;

    // Radix-2 long division by three, a few bits at a time.
    always_comb begin
        logic [2:0] tv;
        logic [2:0] tw;
        n_data = i_data;
        for (int s = 0; s < wpfc_pkg::MEAN_STEPS; s++) begin
            tv = {n_data.m.remv, n_data.m.dv[wpfc_pkg::MEAN_BITS-1]};
            tw = {n_data.m.remw, n_data.m.dw[wpfc_pkg::MEAN_BITS-1]};
            n_data.m.dv = {n_data.m.dv[wpfc_pkg::MEAN_BITS-2:0], 1'b0};
            n_data.m.dw = {n_data.m.dw[wpfc_pkg::MEAN_BITS-2:0], 1'b0};
            n_data.m.qv = {n_data.m.qv[wpfc_pkg::MEAN_BITS-2:0], (tv >= 3'd3)};
            n_data.m.qw = {n_data.m.qw[wpfc_pkg::MEAN_BITS-2:0], (tw >= 3'd3)};
            n_data.m.remv = (tv >= 3'd3) ? 2'(tv - 3'd3) : tv[1:0];
            n_data.m.remw = (tw >= 3'd3) ? 2'(tw - 3'd3) : tw[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/wpfc_div_cell.sv =====
// One cell of the restoring divider chain: one quotient bit per channel.
// Handles the three rescaled channels in parallel; depends on wpfc_pkg.
`default_nettype none

module wpfc_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wpfc_pkg::t_dst     i_data,
    output logic               o_valid,
    output wpfc_pkg::t_dst     o_data
);

    logic           r_valid;
    wpfc_pkg::t_dst r_data;
    wpfc_pkg::t_dst n_data;

    // Shift in the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        logic [wpfc_pkg::DATA_W:0] r;
        logic                      ge;
        n_data = i_data;
        for (int c = 0; c < wpfc_pkg::LANES; c++) begin
            r  = {i_data.lane[c].rem, i_data.lane[c].lo[wpfc_pkg::DATA_W-1]};
            ge = (r >= {1'b0, i_data.lane[c].w});
            n_data.lane[c].rem = ge ? wpfc_pkg::DATA_W'(r - {1'b0, i_data.lane[c].w})
                                    : r[wpfc_pkg::DATA_W-1:0];
            n_data.lane[c].lo  = {i_data.lane[c].lo[wpfc_pkg::DATA_W-2:0], 1'b0};
            n_data.lane[c].q   = {i_data.lane[c].q[wpfc_pkg::DATA_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/weighted_pixel_format_convert.sv =====
// Weighted pixel format converter, top level.
// Converts one weighted pixel per item between gray, packed RGB and separate RGB.
//
// Channels: i_pix takes input items, o_pix delivers one result item per input
// item, i_cfg writes source_format (index 0) and target_format (index 1); only
// the low two bits of the data are kept and other indexes are ignored. The
// configuration channel is always ready; change formats only while idle.
// Throughput: one item per cycle while the receiver keeps up. The path has
// 41 register stages, the first loaded at the accepting edge: a sum stage,
// five divide-by-three cells, a multiplier stage, a divider setup stage, 32
// restoring divider cells (one quotient bit each) and the output register.
// When the receiver stalls with a result waiting, the whole chain holds and
// i_pix.ready drops in the same cycle; nothing is lost. Reset clears all
// valid bits and sets both formats to gray. Format code three gives zeros.
// Depends on wpfc_pkg, wpfc_if, wpfc_mean_cell and wpfc_div_cell.
`default_nettype none

module weighted_pixel_format_convert (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wpfc_in_if.sink    i_pix,
    wpfc_out_if.source o_pix,
    wpfc_cfg_if.sink   i_cfg
);

    localparam int W = wpfc_pkg::DATA_W;

    // Format registers.
    logic [1:0] r_src;
    logic [1:0] r_dst;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= wpfc_pkg::FMT_GRAY;
            r_dst <= wpfc_pkg::FMT_GRAY;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == wpfc_pkg::CFG_SOURCE_FORMAT) begin
                r_src <= i_cfg.data[1:0];
            end else if (i_cfg.index == wpfc_pkg::CFG_TARGET_FORMAT) begin
                r_dst <= i_cfg.data[1:0];
            end
        end
    end

    // Global advance: the chain moves when the output register can take an item.
    logic en;
    logic r_out_valid;
    assign en          = !r_out_valid || o_pix.ready;
    assign i_pix.ready = en;

    // Sum stage.
    logic           r_sum_valid;
    wpfc_pkg::t_mst r_sum;
    wpfc_pkg::t_mst n_sum;

    always_comb begin
        logic [wpfc_pkg::SUM_W-1:0] sv;
        logic [wpfc_pkg::SUM_W-1:0] sw;
        sv = wpfc_pkg::SUM_W'(i_pix.in_red_value) + wpfc_pkg::SUM_W'(i_pix.in_green_value)
           + wpfc_pkg::SUM_W'(i_pix.in_blue_value);
        sw = wpfc_pkg::SUM_W'(i_pix.in_red_weight) + wpfc_pkg::SUM_W'(i_pix.in_green_weight)
           + wpfc_pkg::SUM_W'(i_pix.in_blue_weight);
        n_sum.pix.rv   = i_pix.in_red_value;
        n_sum.pix.gv   = i_pix.in_green_value;
        n_sum.pix.bv   = i_pix.in_blue_value;
        n_sum.pix.rw   = i_pix.in_red_weight;
        n_sum.pix.gw   = i_pix.in_green_weight;
        n_sum.pix.bw   = i_pix.in_blue_weight;
        n_sum.pix.last = i_pix.in_last;
        n_sum.m.dv     = wpfc_pkg::MEAN_BITS'(sv);
        n_sum.m.dw     = wpfc_pkg::MEAN_BITS'(sw);
        n_sum.m.qv     = '0;
        n_sum.m.qw     = '0;
        n_sum.m.remv   = '0;
        n_sum.m.remw   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (en) begin
            r_sum_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum <= n_sum;
        end
    end

    // Divide-by-three cells.
    logic           mean_valid [wpfc_pkg::MEAN_CELLS+1];
    wpfc_pkg::t_mst mean_data  [wpfc_pkg::MEAN_CELLS+1];
    assign mean_valid[0] = r_sum_valid;
    assign mean_data[0]  = r_sum;

    for (genvar g = 0; g < wpfc_pkg::MEAN_CELLS; g++) begin : g_mean
        wpfc_mean_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (mean_valid[g]),
            .i_data  (mean_data[g]),
            .o_valid (mean_valid[g+1]),
            .o_data  (mean_data[g+1])
        );
    end

    // Multiplier stage: each channel value times the mean weight.
    logic                 r_mul_valid;
    wpfc_pkg::t_pix       r_mul_pix;
    logic [W-1:0]         r_mul_mv;
    logic [W-1:0]         r_mul_mw;
    logic [2:0][2*W-1:0]  r_mul_prod;
    wpfc_pkg::t_mst       mres;
    logic [W-1:0]         mres_mw;

    assign mres    = mean_data[wpfc_pkg::MEAN_CELLS];
    assign mres_mw = mres.m.qw[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (en) begin
            r_mul_valid <= mean_valid[wpfc_pkg::MEAN_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mul_pix     <= mres.pix;
            r_mul_mv      <= mres.m.qv[W-1:0];
            r_mul_mw      <= mres_mw;
            r_mul_prod[0] <= (2*W)'(mres.pix.rv) * (2*W)'(mres_mw);
            r_mul_prod[1] <= (2*W)'(mres.pix.gv) * (2*W)'(mres_mw);
            r_mul_prod[2] <= (2*W)'(mres.pix.bv) * (2*W)'(mres_mw);
        end
    end

    // Divider setup: overflow when the high half reaches the divisor.
    logic           r_ini_valid;
    wpfc_pkg::t_dst r_ini;
    wpfc_pkg::t_dst n_ini;
    logic [2:0][W-1:0] wsel;

    assign wsel[0] = r_mul_pix.rw;
    assign wsel[1] = r_mul_pix.gw;
    assign wsel[2] = r_mul_pix.bw;

    always_comb begin
        n_ini.pix = r_mul_pix;
        n_ini.mv  = r_mul_mv;
        n_ini.mw  = r_mul_mw;
        for (int c = 0; c < wpfc_pkg::LANES; c++) begin
            n_ini.lane[c].w    = wsel[c];
            n_ini.lane[c].rem  = r_mul_prod[c][2*W-1:W];
            n_ini.lane[c].lo   = r_mul_prod[c][W-1:0];
            n_ini.lane[c].q    = '0;
            n_ini.lane[c].sat  = (r_mul_prod[c][2*W-1:W] >= wsel[c]);
            n_ini.lane[c].zero = (wsel[c] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ini_valid <= 1'b0;
        end else if (en) begin
            r_ini_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ini <= n_ini;
        end
    end

    // Restoring divider cells.
    logic           div_valid [wpfc_pkg::DIV_CELLS+1];
    wpfc_pkg::t_dst div_data  [wpfc_pkg::DIV_CELLS+1];
    assign div_valid[0] = r_ini_valid;
    assign div_data[0]  = r_ini;

    for (genvar g = 0; g < wpfc_pkg::DIV_CELLS; g++) begin : g_div
        wpfc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_valid[g]),
            .i_data  (div_data[g]),
            .o_valid (div_valid[g+1]),
            .o_data  (div_data[g+1])
        );
    end

    // Output selection by format pair.
    wpfc_pkg::t_dst    dres;
    logic [2:0][W-1:0] resc;
    logic              any_sat;
    logic [5:0][W-1:0] n_val;
    logic              n_sat;
    logic [5:0][W-1:0] r_val;
    logic              r_last;
    logic              r_sat;

    assign dres = div_data[wpfc_pkg::DIV_CELLS];

    always_comb begin
        any_sat = 1'b0;
        for (int c = 0; c < wpfc_pkg::LANES; c++) begin
            if (dres.lane[c].zero) begin
                resc[c] = '0;
            end else if (dres.lane[c].sat) begin
                resc[c] = '1;
                any_sat = 1'b1;
            end else begin
                resc[c] = dres.lane[c].q;
            end
        end
    end

    always_comb begin
        n_val = '0;
        n_sat = 1'b0;
        if (r_src == wpfc_pkg::FMT_GRAY || r_src == wpfc_pkg::FMT_PACKED
                || r_src == wpfc_pkg::FMT_SEPARATE) begin
            case (r_dst)
                wpfc_pkg::FMT_GRAY: begin
                    n_val[0] = (r_src == wpfc_pkg::FMT_GRAY) ? dres.pix.rv : dres.mv;
                    n_val[3] = (r_src == wpfc_pkg::FMT_SEPARATE) ? dres.mw : dres.pix.rw;
                end
                wpfc_pkg::FMT_PACKED: begin
                    if (r_src == wpfc_pkg::FMT_GRAY) begin
                        n_val[0] = dres.pix.rv;
                        n_val[1] = dres.pix.rv;
                        n_val[2] = dres.pix.rv;
                        n_val[3] = dres.pix.rw;
                    end else if (r_src == wpfc_pkg::FMT_PACKED) begin
                        n_val[0] = dres.pix.rv;
                        n_val[1] = dres.pix.gv;
                        n_val[2] = dres.pix.bv;
                        n_val[3] = dres.pix.rw;
                    end else begin
                        n_val[0] = resc[0];
                        n_val[1] = resc[1];
                        n_val[2] = resc[2];
                        n_val[3] = dres.mw;
                        n_sat    = any_sat;
                    end
                end
                wpfc_pkg::FMT_SEPARATE: begin
                    n_val[0] = dres.pix.rv;
                    n_val[1] = (r_src == wpfc_pkg::FMT_GRAY) ? dres.pix.rv : dres.pix.gv;
                    n_val[2] = (r_src == wpfc_pkg::FMT_GRAY) ? dres.pix.rv : dres.pix.bv;
                    n_val[3] = dres.pix.rw;
                    n_val[4] = (r_src == wpfc_pkg::FMT_SEPARATE) ? dres.pix.gw : dres.pix.rw;
                    n_val[5] = (r_src == wpfc_pkg::FMT_SEPARATE) ? dres.pix.bw : dres.pix.rw;
                end
                default: begin
                    n_val = '0;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid[wpfc_pkg::DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_val  <= n_val;
            r_last <= dres.pix.last;
            r_sat  <= n_sat;
        end
    end

    assign o_pix.valid            = r_out_valid;
    assign o_pix.out_red_value    = r_val[0];
    assign o_pix.out_green_value  = r_val[1];
    assign o_pix.out_blue_value   = r_val[2];
    assign o_pix.out_red_weight   = r_val[3];
    assign o_pix.out_green_weight = r_val[4];
    assign o_pix.out_blue_weight  = r_val[5];
    assign o_pix.out_last         = r_last;
    assign o_pix.out_saturated    = r_sat;

    // Clamping happens only on the separate to packed conversion.
    a_sat_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_sat |-> r_src == wpfc_pkg::FMT_SEPARATE
                                 && r_dst == wpfc_pkg::FMT_PACKED)
        else $error("saturation flagged outside separate to packed");

    // A gray target leaves the green and blue fields at zero.
    a_gray_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_dst == wpfc_pkg::FMT_GRAY |-> r_val[1] == '0 && r_val[2] == '0
                                                       && r_val[4] == '0 && r_val[5] == '0)
        else $error("gray result carries color fields");

    // An undefined source format yields an all-zero result.
    a_bad_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_src == wpfc_pkg::FMT_UNDEF |-> r_val == '0 && !r_sat)
        else $error("undefined format produced data");

endmodule

`default_nettype wire

// ===== tb/tb_weighted_pixel_format_convert.sv =====
// Testbench for the weighted pixel format converter.
// Drives pixel items under every source and target format, predicts each result
// and checks it field by field; depends on wpfc_pkg, wpfc_if and the top level.
`timescale 1ns / 1ps

module tb_weighted_pixel_format_convert;

    localparam int LATENCY   = 41;
    localparam int WDOG_MAX  = 5000;
    localparam logic [1:0] FMT_BAD = 2'd3;

    typedef struct {
        logic [31:0] rv, gv, bv, rw, gw, bw;
        logic        last;
    } t_in;

    typedef struct {
        logic [31:0] rv, gv, bv, rw, gw, bw;
        logic        last, sat;
    } t_res;

    // Directed row: the pixel, the formats it runs under, optional typed result.
    typedef struct {
        logic [1:0] src, dst;
        t_in        pix;
        bit         typed;
        t_res       res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    wpfc_in_if  pix_in();
    wpfc_out_if pix_out();
    wpfc_cfg_if cfg();

    weighted_pixel_format_convert dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_in.sink),
        .o_pix  (pix_out.source),
        .i_cfg  (cfg.sink)
    );

    // Predictor state: the formats currently loaded into the block.
    logic [1:0] cur_src, cur_dst;
    t_res       pending_pixels[$];
    int         errors;
    int         accepted_in, accepted_out;
    int         idle_cycles;
    bit         stall_enable;
    bit         long_holdoff;
    int         fmt_hits[4][4];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mean of three as the floor of the 34-bit sum over three.
    function automatic logic [31:0] mean_of_three(logic [31:0] a, logic [31:0] b,
                                                  logic [31:0] c);
        logic [33:0] s;
        s = {2'b0, a} + {2'b0, b} + {2'b0, c};
        return 32'(s / 34'd3);
    endfunction

    function automatic logic [31:0] rescale_channel(logic [31:0] v, logic [31:0] m,
                                                    logic [31:0] w, ref logic sat);
        logic [63:0] q;
        if (w == 32'd0) return 32'd0;
        q = ({32'd0, v} * {32'd0, m}) / {32'd0, w};
        if (q > 64'hFFFF_FFFF) begin
            sat = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return q[31:0];
    endfunction

    // Converted pixel for the given formats.
    function automatic t_res convert_pixel(logic [1:0] src, logic [1:0] dst, t_in p);
        t_res r;
        logic [31:0] m;
        logic sat;
        r = '{default: '0};
        sat = 1'b0;
        r.last = p.last;
        if (src != FMT_BAD && dst != FMT_BAD) begin
            case (wpfc_pkg::t_fmt'(dst))
                wpfc_pkg::FMT_GRAY: begin
                    if (src == wpfc_pkg::FMT_GRAY) begin
                        r.rv = p.rv; r.rw = p.rw;
                    end else if (src == wpfc_pkg::FMT_PACKED) begin
                        r.rv = mean_of_three(p.rv, p.gv, p.bv); r.rw = p.rw;
                    end else begin
                        r.rv = mean_of_three(p.rv, p.gv, p.bv);
                        r.rw = mean_of_three(p.rw, p.gw, p.bw);
                    end
                end
                wpfc_pkg::FMT_PACKED: begin
                    if (src == wpfc_pkg::FMT_GRAY) begin
                        r.rv = p.rv; r.gv = p.rv; r.bv = p.rv; r.rw = p.rw;
                    end else if (src == wpfc_pkg::FMT_PACKED) begin
                        r.rv = p.rv; r.gv = p.gv; r.bv = p.bv; r.rw = p.rw;
                    end else begin
                        m = mean_of_three(p.rw, p.gw, p.bw);
                        r.rv = rescale_channel(p.rv, m, p.rw, sat);
                        r.gv = rescale_channel(p.gv, m, p.gw, sat);
                        r.bv = rescale_channel(p.bv, m, p.bw, sat);
                        r.rw = m;
                    end
                end
                default: begin
                    if (src == wpfc_pkg::FMT_GRAY) begin
                        r.rv = p.rv; r.gv = p.rv; r.bv = p.rv;
                        r.rw = p.rw; r.gw = p.rw; r.bw = p.rw;
                    end else if (src == wpfc_pkg::FMT_PACKED) begin
                        r.rv = p.rv; r.gv = p.gv; r.bv = p.bv;
                        r.rw = p.rw; r.gw = p.rw; r.bw = p.rw;
                    end else begin
                        r.rv = p.rv; r.gv = p.gv; r.bv = p.bv;
                        r.rw = p.rw; r.gw = p.gw; r.bw = p.bw;
                    end
                end
            endcase
        end
        r.sat = sat;
        return r;
    endfunction

    // Value mix that favors the extremes and small numbers.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 16));
            3: return 32'h0001_0000 + 32'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in random_pixel();
        t_in p;
        p.rv = pick_word(); p.gv = pick_word(); p.bv = pick_word();
        p.rw = pick_word(); p.gw = pick_word(); p.bw = pick_word();
        p.last = 1'($urandom_range(0, 1));
        return p;
    endfunction

    // Write one register; the channel is sampled at the rising edge.
    task automatic write_register(logic [wpfc_pkg::CFG_IDX_W-1:0] idx, logic [1:0] value);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (!cfg.ready);
        if (idx == wpfc_pkg::CFG_SOURCE_FORMAT) cur_src = value;
        else if (idx == wpfc_pkg::CFG_TARGET_FORMAT) cur_dst = value;
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // Wait until every result has come back, plus the pipeline depth.
    task automatic drain_pipeline();
        wait (pending_pixels.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Called at a falling edge; the input goes quiet before the formats change.
    task automatic set_formats(logic [1:0] src, logic [1:0] dst);
        if (src == cur_src && dst == cur_dst) return;
        pix_in.valid <= 1'b0;
        drain_pipeline();
        write_register(wpfc_pkg::CFG_SOURCE_FORMAT, src);
        write_register(wpfc_pkg::CFG_TARGET_FORMAT, dst);
    endtask

    // Offer one item at a falling edge, sometimes after a random gap; valid stays
    // high afterwards so that the next item can follow without a gap.
    task automatic send_pixel(t_in p, bit typed, t_res typed_res);
        t_res r;
        if (stall_enable && $urandom_range(0, 7) == 0) begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        pix_in.valid           <= 1'b1;
        pix_in.in_red_value    <= p.rv;
        pix_in.in_green_value  <= p.gv;
        pix_in.in_blue_value   <= p.bv;
        pix_in.in_red_weight   <= p.rw;
        pix_in.in_green_weight <= p.gw;
        pix_in.in_blue_weight  <= p.bw;
        pix_in.in_last         <= p.last;
        do @(posedge i_clk); while (!pix_in.ready);
        r = typed ? typed_res : convert_pixel(cur_src, cur_dst, p);
        pending_pixels.push_back(r);
        fmt_hits[cur_src][cur_dst]++;
        accepted_in++;
        @(negedge i_clk);
    endtask

    // Receiver side: random stall bursts, plus one long hold-off on request.
    initial begin
        int stall;
        pix_out.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_holdoff) begin
                pix_out.ready <= 1'b0;
                repeat (200) @(negedge i_clk);
                long_holdoff = 1'b0;
                pix_out.ready <= 1'b1;
            end else if (stall_enable && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 15);
                pix_out.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                pix_out.ready <= 1'b1;
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            accepted_out++;
            if (pending_pixels.size() == 0) begin
                $error("result item with no expectation waiting");
                errors++;
            end else begin
                e = pending_pixels.pop_front();
                if (pix_out.out_red_value !== e.rv) begin
                    $error("out_red_value: expected %h, got %h", e.rv, pix_out.out_red_value);
                    errors++;
                end
                if (pix_out.out_green_value !== e.gv) begin
                    $error("out_green_value: expected %h, got %h", e.gv,
                           pix_out.out_green_value);
                    errors++;
                end
                if (pix_out.out_blue_value !== e.bv) begin
                    $error("out_blue_value: expected %h, got %h", e.bv, pix_out.out_blue_value);
                    errors++;
                end
                if (pix_out.out_red_weight !== e.rw) begin
                    $error("out_red_weight: expected %h, got %h", e.rw, pix_out.out_red_weight);
                    errors++;
                end
                if (pix_out.out_green_weight !== e.gw) begin
                    $error("out_green_weight: expected %h, got %h", e.gw,
                           pix_out.out_green_weight);
                    errors++;
                end
                if (pix_out.out_blue_weight !== e.bw) begin
                    $error("out_blue_weight: expected %h, got %h", e.bw,
                           pix_out.out_blue_weight);
                    errors++;
                end
                if (pix_out.out_last !== e.last) begin
                    $error("out_last: expected %b, got %b", e.last, pix_out.out_last);
                    errors++;
                end
                if (pix_out.out_saturated !== e.sat) begin
                    $error("out_saturated: expected %b, got %b", e.sat, pix_out.out_saturated);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles where nothing moves on any channel.
    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
            (cfg.valid && cfg.ready) || (pending_pixels.size() == 0 && !pix_in.valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired with %0d results outstanding", pending_pixels.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        t_row rows[$];
        t_row row;
        t_in  p;
        t_res z;
        int   phase;
        errors = 0; accepted_in = 0; accepted_out = 0; idle_cycles = 0;
        stall_enable = 1'b0; long_holdoff = 1'b0;
        cur_src = wpfc_pkg::FMT_GRAY; cur_dst = wpfc_pkg::FMT_GRAY;
        foreach (fmt_hits[a, b]) fmt_hits[a][b] = 0;
        i_rst_n = 1'b0;
        pix_in.valid = 1'b0;
        pix_in.in_red_value = '0; pix_in.in_green_value = '0; pix_in.in_blue_value = '0;
        pix_in.in_red_weight = '0; pix_in.in_green_weight = '0;
        pix_in.in_blue_weight = '0; pix_in.in_last = 1'b0;
        cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        z = '{default: '0};
        // Gray to gray straight after reset: a plain copy of value and weight.
        row = '{wpfc_pkg::FMT_GRAY, wpfc_pkg::FMT_GRAY, '{32'hFFFF_FFFF, 32'h1, 32'h2,
                32'hFFFF_FFFF, 32'h3, 32'h4, 1'b1}, 1'b1, z};
        row.res.rv = 32'hFFFF_FFFF; row.res.rw = 32'hFFFF_FFFF; row.res.last = 1'b1;
        rows.push_back(row);
        // Separate to packed with every weight zero: all channels give zero.
        row = '{wpfc_pkg::FMT_SEPARATE, wpfc_pkg::FMT_PACKED, '{32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b1, z};
        rows.push_back(row);
        // Huge value over a tiny weight: quotient clamps and flags saturation.
        row = '{wpfc_pkg::FMT_SEPARATE, wpfc_pkg::FMT_PACKED, '{32'hFFFF_FFFF, 32'h0,
                32'h0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1, z};
        row.res.rv = 32'hFFFF_FFFF; row.res.rw = 32'hAAAA_AAAA;
        row.res.last = 1'b1; row.res.sat = 1'b1;
        rows.push_back(row);
        // Zero weight on one plane only, others rescaled by the predictor.
        rows.push_back('{wpfc_pkg::FMT_SEPARATE, wpfc_pkg::FMT_PACKED, '{32'h0001_0000,
                32'h0002_0000, 32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0002_0000, 1'b0},
                1'b0, z});
        // Format code three on either side gives zeros with last passed through.
        row = '{FMT_BAD, wpfc_pkg::FMT_GRAY, '{32'h5, 32'h6, 32'h7, 32'h8, 32'h9, 32'hA,
                1'b1}, 1'b1, z};
        row.res.last = 1'b1;
        rows.push_back(row);
        row.src = wpfc_pkg::FMT_PACKED; row.dst = FMT_BAD;
        rows.push_back(row);
        // Every valid pair with extremes and small values.
        for (int s = 0; s < 3; s++)
            for (int d = 0; d < 3; d++) begin
                rows.push_back('{2'(s), 2'(d), '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b0, z});
                rows.push_back('{2'(s), 2'(d), '{32'h0001_8000, 32'h7, 32'hFFFF_0000,
                        32'h0000_4000, 32'h0003_0000, 32'h11, 1'b0}, 1'b0, z});
            end

        foreach (rows[i]) begin
            set_formats(rows[i].src, rows[i].dst);
            send_pixel(rows[i].pix, rows[i].typed, rows[i].res);
        end

        // Random phases, each under one pair of formats, ending with gaps off.
        // The long hold-off phase sends more items than the pipeline can hold.
        stall_enable = 1'b1;
        for (phase = 0; phase < 30; phase++) begin
            if (phase == 27) stall_enable = 1'b0;
            if (phase < 27 && phase % 5 == 4)
                set_formats(FMT_BAD, 2'($urandom_range(0, 3)));
            else
                set_formats(2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)));
            if (phase == 10) long_holdoff = 1'b1;
            repeat ((phase == 10) ? 60 : 30) begin
                p = random_pixel();
                send_pixel(p, 1'b0, z);
            end
        end
        pix_in.valid <= 1'b0;

        // End of run: drain, settle, then report.
        wait (pending_pixels.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("%0d items sent, %0d results checked; separate to packed ran %0d items.",
                 accepted_in, accepted_out,
                 fmt_hits[wpfc_pkg::FMT_SEPARATE][wpfc_pkg::FMT_PACKED]);
        $display("All nine format pairs, format code three and a long output stall covered.");
        if (errors == 0 && pending_pixels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/wpfc_pkg.sv
rtl/core/wpfc_if.sv
rtl/core/wpfc_mean_cell.sv
rtl/core/wpfc_div_cell.sv
rtl/core/weighted_pixel_format_convert.sv
tb/tb_weighted_pixel_format_convert.sv
